// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the bitmap block allocator modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define BBA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define BBA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants of the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

   // Bitmap geometry
   localparam int unsigned MAP_BYTES_DEFAULT = 512;
   localparam int unsigned REACH_BYTES       = 512;   // bytes addressable by a 12-bit block
   localparam int unsigned BYTE_W            = 8;
   localparam int unsigned ROW_BYTES         = 8;
   localparam int unsigned ROW_BITS          = ROW_BYTES * BYTE_W;
   localparam int unsigned BLOCK_W           = 12;
   localparam int unsigned BYTE_POS_W        = 3;     // block bits that select a bit in a byte
   localparam int unsigned BIT_POS_W         = 6;     // block bits that select a bit in a row
   localparam logic [BYTE_W-1:0] FULL_BYTE   = 8'hFF;

   // Stream widths
   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned REQ_USER_W = 2;
   localparam int unsigned RSP_DATA_W = 16;
   localparam int unsigned RSP_USER_W = 1;

   // Request kinds
   typedef enum logic [1:0] {
      KIND_ALLOC     = 2'd0,
      KIND_MARK_USED = 2'd1,
      KIND_MARK_FREE = 2'd2
   } kind_type;

   // Result status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MARK,
      ST_RESP
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic take_req;
      logic scan_step;
      logic alloc_commit;
      logic full_commit;
      logic mark_commit;
      logic load_out;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic req_alloc;
      logic req_mark;
      logic row_has_free;
      logic last_row;
      logic out_free;
   } dp_status_type;

endpackage

// ===== hdl/bba_ram.sv =====
// ----------------------------------------------------------------------------
// bba_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bba_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/bba_datapath.sv =====
// ----------------------------------------------------------------------------
// bba_datapath
// Bitmap storage, row scan, bit update, result and output registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bba_datapath #(
   parameter int unsigned MAP_BYTES = bba_pkg::MAP_BYTES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [bba_pkg::BLOCK_W-1:0]   req_block,
   input  logic [1:0]                    req_kind,
   input  bba_pkg::dp_cmd_type           cmd,
   output bba_pkg::dp_status_type        status,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bba_pkg::BLOCK_W-1:0]   rsp_block,
   output logic                          rsp_status
);
   import bba_pkg::*;

   localparam int unsigned LIMIT  = (MAP_BYTES < REACH_BYTES) ? MAP_BYTES : REACH_BYTES;
   localparam int unsigned ROWS   = (LIMIT + ROW_BYTES - 1) / ROW_BYTES;
   localparam int unsigned ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int unsigned LIM_W  = BLOCK_W - BYTE_POS_W + 1;
   localparam logic [LIM_W-1:0] LIMIT_V = LIM_W'(LIMIT);

   logic [ROW_AW-1:0]    row_ff, row_in;
   logic [1:0]           kind_ff, kind_in;
   logic [BLOCK_W-1:0]   blk_ff, blk_in;
   logic [ROWS-1:0]      row_valid_ff, row_valid_in;
   logic [BLOCK_W-1:0]   res_block_ff, res_block_in;
   logic                 res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [BLOCK_W-1:0]   rsp_block_ff, rsp_block_in;
   logic                 rsp_status_ff, rsp_status_in;

   logic                 rd_en, wr_en;
   logic [ROW_AW-1:0]    rd_addr, req_row;
   logic [ROW_BITS-1:0]  rd_data, wr_data;
   logic [ROW_BITS-1:0]  row_word, scan_word, tail_mask, bit_sel, free_sel;
   logic [BIT_POS_W-1:0] free_pos;
   logic [BLOCK_W-1:0]   granted;
   logic                 req_alloc, req_in_range, req_mark, last_row;

   // Decode the request on the input side
   assign req_row      = req_block[BIT_POS_W +: ROW_AW];
   assign req_alloc    = (req_kind == KIND_ALLOC);
   assign req_in_range = ({1'b0, req_block[BLOCK_W-1:BYTE_POS_W]} < LIMIT_V);
   assign req_mark     = ((req_kind == KIND_MARK_USED) || (req_kind == KIND_MARK_FREE))
                         && req_in_range;

   // Row word as stored; rows never written read as all free
   assign row_word = row_valid_ff[row_ff] ? rd_data : '0;
   assign last_row = (row_ff == ROW_AW'(ROWS - 1));

   // Bytes past the bitmap end in the last row count as full
   always_comb begin
      tail_mask = '0;
      for (int j = 0; j < ROW_BYTES; j++) begin
         if (((ROWS - 1) * ROW_BYTES + j) >= LIMIT) begin
            tail_mask[j*BYTE_W +: BYTE_W] = FULL_BYTE;
         end
      end
   end

   assign scan_word = row_word | (last_row ? tail_mask : '0);

   // Find the lowest clear bit of the row
   always_comb begin
      free_pos = '0;
      for (int i = ROW_BITS - 1; i >= 0; i--) begin
         if (!scan_word[i]) begin
            free_pos = BIT_POS_W'(i);
         end
      end
   end

   assign granted  = {(BLOCK_W - BIT_POS_W)'(row_ff), free_pos};
   assign free_sel = ROW_BITS'(1) << free_pos;
   assign bit_sel  = ROW_BITS'(1) << blk_ff[BIT_POS_W-1:0];

   // Memory access
   assign rd_en   = (cmd.take_req && (req_alloc || req_mark)) || cmd.scan_step;
   assign rd_addr = cmd.take_req ? (req_alloc ? '0 : req_row) : row_ff + 1'b1;
   assign wr_en   = cmd.alloc_commit || cmd.mark_commit;

   always_comb begin
      if (cmd.alloc_commit) begin
         wr_data = row_word | free_sel;
      end else if (kind_ff == KIND_MARK_USED) begin
         wr_data = row_word | bit_sel;
      end else begin
         wr_data = row_word & ~bit_sel;
      end
   end

   bba_ram #(
      .WIDTH (ROW_BITS),
      .DEPTH (ROWS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (row_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Next values of the request, row pointer and result
   always_comb begin
      row_in        = row_ff;
      kind_in       = kind_ff;
      blk_in        = blk_ff;
      res_block_in  = res_block_ff;
      res_status_in = res_status_ff;
      if (cmd.take_req) begin
         row_in        = req_alloc ? '0 : req_row;
         kind_in       = req_kind;
         blk_in        = req_block;
         res_block_in  = req_block;
         res_status_in = STATUS_OK;
      end
      if (cmd.scan_step) begin
         row_in = row_ff + 1'b1;
      end
      if (cmd.alloc_commit) begin
         res_block_in  = granted;
         res_status_in = STATUS_OK;
      end
      if (cmd.full_commit) begin
         res_block_in  = '0;
         res_status_in = STATUS_FULL;
      end
   end

   // Mark rows that hold written data
   always_comb begin
      row_valid_in = row_valid_ff;
      if (wr_en) begin
         row_valid_in[row_ff] = 1'b1;
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_block_in  = rsp_block_ff;
      rsp_status_in = rsp_status_ff;
      if (cmd.load_out) begin
         rsp_valid_in  = 1'b1;
         rsp_block_in  = res_block_ff;
         rsp_status_in = res_status_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff        <= row_in;
      kind_ff       <= kind_in;
      blk_ff        <= blk_in;
      res_block_ff  <= res_block_in;
      res_status_ff <= res_status_in;
      rsp_block_ff  <= rsp_block_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign status.req_alloc    = req_alloc;
   assign status.req_mark     = req_mark;
   assign status.row_has_free = ~&scan_word;
   assign status.last_row     = last_row;
   assign status.out_free     = !rsp_valid_ff || rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_block  = rsp_block_ff;
   assign rsp_status = rsp_status_ff;

   `BBA_ASSERT(a_alloc_has_free, clock, reset, cmd.alloc_commit |-> status.row_has_free, "allocation committed on a full row")
   `BBA_ASSERT(a_full_gives_zero, clock, reset, rsp_valid_ff && (rsp_status_ff == STATUS_FULL) |-> (rsp_block_ff == '0), "full status with nonzero block")

endmodule

// ===== hdl/bba_ctrl.sv =====
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer of the allocator: accept, scan or mark, hand over the result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bba_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  bba_pkg::dp_status_type status,
   output bba_pkg::dp_cmd_type    cmd
);
   import bba_pkg::*;

   state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (status.req_alloc) begin
                  state_in = ST_SCAN;
               end else if (status.req_mark) begin
                  state_in = ST_MARK;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_SCAN: begin
            if (status.row_has_free || status.last_row) begin
               state_in = ST_RESP;
            end
         end
         ST_MARK: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Commands to the datapath
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.take_req = req_valid;
         end
         ST_SCAN: begin
            if (status.row_has_free) begin
               cmd.alloc_commit = 1'b1;
            end else if (status.last_row) begin
               cmd.full_commit = 1'b1;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_MARK: begin
            cmd.mark_commit = 1'b1;
         end
         ST_RESP: begin
            cmd.load_out = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `BBA_ASSERT(a_take_leaves_idle, clock, reset, cmd.take_req |=> (state_ff != ST_IDLE), "accepted request did not start work")
   `BBA_ASSERT(a_one_command, clock, reset, $onehot0({cmd.take_req, cmd.scan_step, cmd.alloc_commit, cmd.full_commit, cmd.mark_commit, cmd.load_out}), "more than one datapath command")

endmodule

// ===== hdl/bitmap_block_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// Used/free bitmap of storage blocks with first-free allocation and marking.
//
// One request is in work at a time. The bitmap is held in a RAM of 64-bit
// rows (eight bitmap bytes, 64 blocks each) and one row is read per cycle.
// An allocate scans k rows up to the first free block, k from 1 to
// ceil(min(MAP_BYTES, 512)/8) (64 with the default 512-byte map, and never
// more, since a 12-bit block number reaches only the first 512 bytes); a
// full map costs the whole scan. Marking a block used or free goes through
// a row read, a row write and the result; an unused kind or a block past
// the map goes straight to the result. Rows that were never written read
// as free, so the bitmap is empty right after reset with no clearing pass.
// The result sits in an output register until taken; a stalled result
// delays the next request by the stall.
// ----------------------------------------------------------------------------
module bitmap_block_allocator #(
   parameter int unsigned MAP_BYTES = bba_pkg::MAP_BYTES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // request stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [bba_pkg::REQ_DATA_W-1:0]   req_tdata,  // [11:0] block_index, rest zero
   input  logic [bba_pkg::REQ_USER_W-1:0]   req_tuser,  // [1:0] kind
   // result stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [bba_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // [11:0] granted_block, rest zero
   output logic [bba_pkg::RSP_USER_W-1:0]   rsp_tuser   // [0] status
);
   import bba_pkg::*;

   dp_cmd_type         cmd;
   dp_status_type      status;
   logic [BLOCK_W-1:0] rsp_block;
   logic               rsp_status;

   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   bba_datapath #(
      .MAP_BYTES (MAP_BYTES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_block  (req_tdata[BLOCK_W-1:0]),
      .req_kind   (req_tuser),
      .cmd        (cmd),
      .status     (status),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_block  (rsp_block),
      .rsp_status (rsp_status)
   );

   // Pack the result transfer
   assign rsp_tdata = {{(RSP_DATA_W - BLOCK_W){1'b0}}, rsp_block};
   assign rsp_tuser = rsp_status;

endmodule

// ===== dv/bitmap_block_allocator_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_block_allocator_check
// Watches the request and result streams of the bitmap block allocator,
// keeps its own copy of the used/free bitmap, works out the grant for every
// accepted request and compares each result transfer against the oldest
// grant still owed. Hands the mismatch count and the number of grants still
// owed to the testbench top.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_check
   import bba_pkg::*;
#(
   parameter int unsigned MAP_BYTES = MAP_BYTES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [11:0] block_index, rest zero
   input  logic [REQ_USER_W-1:0] req_tuser,   // [1:0] kind
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // [11:0] granted_block, rest zero
   input  logic [RSP_USER_W-1:0] rsp_tuser,   // [0] status
   output int                    mismatch_count,
   output int                    grants_owed
);

   typedef struct packed {
      logic [BLOCK_W-1:0] block;
      logic               status;
   } grant_type;

   // only the first 512 bytes can be named by a 12-bit block number
   localparam int unsigned SCAN_BYTES = (MAP_BYTES < REACH_BYTES) ? MAP_BYTES : REACH_BYTES;

   logic [BYTE_W-1:0] block_used [MAP_BYTES];
   grant_type         expected_grants [$];
   int                errors_seen = 0;

   // Apply one request to the shadow bitmap and return the grant it earns.
   function automatic grant_type predict_grant(input logic [1:0] kind,
                                               input logic [BLOCK_W-1:0] blk);
      grant_type   g;
      int unsigned bit_pos;
      int unsigned byte_pos;
      g.block  = blk;
      g.status = STATUS_OK;
      byte_pos = blk >> BYTE_POS_W;
      case (kind)
         KIND_ALLOC: begin
            // first byte with a clear bit, lowest clear bit in it
            g.block  = '0;
            g.status = STATUS_FULL;
            for (int i = 0; i < SCAN_BYTES && g.status == STATUS_FULL; i++) begin
               if (block_used[i] != FULL_BYTE) begin
                  bit_pos = 0;
                  while (block_used[i][bit_pos]) bit_pos++;
                  block_used[i][bit_pos] = 1'b1;
                  g.block  = BLOCK_W'(i * BYTE_W + bit_pos);
                  g.status = STATUS_OK;
               end
            end
         end
         KIND_MARK_USED, KIND_MARK_FREE: begin
            if (byte_pos < SCAN_BYTES)
               block_used[byte_pos][blk[BYTE_POS_W-1:0]] = (kind == KIND_MARK_USED);
         end
         default: begin
            // unused kind: nothing changes, block echoed
         end
      endcase
      return g;
   endfunction

   // Retire result transfers first, then queue the grant of a new request.
   always @(posedge clock) begin
      grant_type want;
      if (reset) begin
         foreach (block_used[i]) block_used[i] = '0;
         expected_grants.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_grants.size() == 0) begin
               $error("result transfer with nothing owed: granted_block %0d status %0d",
                      rsp_tdata[BLOCK_W-1:0], rsp_tuser[0]);
               errors_seen++;
            end else begin
               want = expected_grants.pop_front();
               if (rsp_tdata[BLOCK_W-1:0] !== want.block) begin
                  $error("granted_block: expected %0d, got %0d",
                         want.block, rsp_tdata[BLOCK_W-1:0]);
                  errors_seen++;
               end
               if (rsp_tuser[0] !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tuser[0]);
                  errors_seen++;
               end
               if (rsp_tdata[RSP_DATA_W-1:BLOCK_W] !== '0) begin
                  $error("tdata padding: expected 0, got %0h",
                         rsp_tdata[RSP_DATA_W-1:BLOCK_W]);
                  errors_seen++;
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_grants.push_back(predict_grant(req_tuser, req_tdata[BLOCK_W-1:0]));
      end
      mismatch_count <= errors_seen;
      grants_owed    <= expected_grants.size();
   end

endmodule

// ===== dv/bitmap_block_allocator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_block_allocator_test
// Drives allocate, mark and unused requests into the bitmap block allocator
// with random gaps and result back-pressure: a directed opening, a random
// phase on a near-empty map, a fill of the low rows so allocations scan past
// them, a random phase with marks spread over the whole block range and a
// final phase with no idling. The checker beside the block does all
// comparing; this top gives the verdict.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_test;
   import bba_pkg::*;

   localparam int unsigned MAP_BYTES   = MAP_BYTES_DEFAULT;
   localparam logic [1:0]  KIND_UNUSED = 2'd3;
   localparam int          LONG_HOLD   = 300;
   localparam int          DRAIN_WAIT  = 80;
   localparam int          CYCLE_LIMIT = 1_000_000;
   localparam int          BLOCK_MAX   = (1 << BLOCK_W) - 1;
   localparam int          FILL_BLOCKS = 512;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // [11:0] block_index, rest zero
   logic [REQ_USER_W-1:0] req_tuser  = '0;   // [1:0] kind
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // [11:0] granted_block, rest zero
   logic [RSP_USER_W-1:0] rsp_tuser;         // [0] status

   int   mismatch_count;
   int   grants_owed;
   int   cycle_count   = 0;
   logic gaps_on       = 1'b1;
   logic long_hold_req = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   bitmap_block_allocator #(.MAP_BYTES(MAP_BYTES)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   bitmap_block_allocator_check #(.MAP_BYTES(MAP_BYTES)) checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .grants_owed    (grants_owed)
   );

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Result sink: random stall bursts, plus one long hold-off on request.
   initial begin
      logic hold_done;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req && !hold_done) begin
            hold_done  = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Offer one request and hold it until the transfer.
   task automatic issue_request(input logic [1:0] kind, input int unsigned blk);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(blk[BLOCK_W-1:0]);
      req_tuser  <= kind;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stop offering and wait until every owed result has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (grants_owed != 0) @(posedge clock);
   endtask

   // Random mix; low_bias keeps most mark targets among the low, busy blocks.
   task automatic random_requests(input int count, input bit low_bias);
      int          roll;
      int unsigned blk;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         if (low_bias && $urandom_range(0, 9) < 7)
            blk = $urandom_range(0, 255);
         else
            blk = $urandom_range(0, BLOCK_MAX);
         if (roll < 40)
            issue_request(KIND_ALLOC, blk);
         else if (roll < 60)
            issue_request(KIND_MARK_USED, blk);
         else if (roll < 93)
            issue_request(KIND_MARK_FREE, blk);
         else
            issue_request(KIND_UNUSED, blk);
      end
   endtask

   initial begin
      int unsigned freed;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed opening: first allocations, byte and row crossings, marks
      issue_request(KIND_ALLOC, 0);
      issue_request(KIND_ALLOC, BLOCK_MAX);
      issue_request(KIND_ALLOC, 0);
      issue_request(KIND_MARK_FREE, 1);
      issue_request(KIND_ALLOC, 'h555);
      issue_request(KIND_MARK_USED, 3);
      issue_request(KIND_MARK_USED, 3);
      issue_request(KIND_MARK_USED, 7);
      for (int n = 0; n < 5; n++) issue_request(KIND_ALLOC, 0);
      issue_request(KIND_MARK_FREE, 200);
      issue_request(KIND_MARK_USED, BLOCK_MAX);
      issue_request(KIND_MARK_FREE, BLOCK_MAX);
      issue_request(KIND_MARK_USED, 'hAAA);
      issue_request(KIND_MARK_FREE, 'h555);
      issue_request(KIND_UNUSED, BLOCK_MAX);
      issue_request(KIND_UNUSED, 0);
      issue_request(KIND_MARK_FREE, 4);
      issue_request(KIND_ALLOC, 0);
      drain_results();

      // near-empty map, with one long result hold-off and two full drains
      random_requests(100, 1'b1);
      long_hold_req <= 1'b1;
      random_requests(150, 1'b1);
      drain_results();
      random_requests(150, 1'b1);
      drain_results();

      // fill the low rows so allocations scan past them, then reuse freed blocks
      for (int b = 0; b < FILL_BLOCKS; b++) issue_request(KIND_MARK_USED, b);
      issue_request(KIND_ALLOC, 0);
      issue_request(KIND_ALLOC, BLOCK_MAX);
      issue_request(KIND_UNUSED, 'h123);
      for (int n = 0; n < 8; n++) begin
         freed = $urandom_range(0, FILL_BLOCKS - 1);
         issue_request(KIND_MARK_FREE, freed);
         issue_request(KIND_ALLOC, 0);
         issue_request(KIND_ALLOC, 0);
      end
      drain_results();

      // marks anywhere in the block range, allocations scan deep
      random_requests(300, 1'b0);
      drain_results();

      // last stretch with no idling on either side
      gaps_on <= 1'b0;
      repeat (6) @(posedge clock);
      random_requests(150, 1'b0);

      drain_results();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0 && grants_owed == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/bba_pkg.sv
hdl/bba_ram.sv
hdl/bba_datapath.sv
hdl/bba_ctrl.sv
hdl/bitmap_block_allocator.sv
dv/bitmap_block_allocator_check.sv
dv/bitmap_block_allocator_test.sv
